// File: hdl/arlh_pkg.sv
// arlh_pkg: item types, the pi lane table and the aes s-box for the lane hash
// no dependencies; imported by arlh_aes_round and aes_round_lane_hash
`timescale 1ns / 1ps

package arlh_pkg;

    localparam int LANE_COUNT = 16;
    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;

    // register indexes of the configuration port
    localparam logic [2:0] REG_SEED_ENABLE = 3'd0;
    localparam logic [2:0] REG_SEED_WORD0  = 3'd1;
    localparam logic [2:0] REG_SEED_WORD1  = 3'd2;
    localparam logic [2:0] REG_SEED_WORD2  = 3'd3;
    localparam logic [2:0] REG_SEED_WORD3  = 3'd4;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  bytes_valid;
        logic        last_word;
    } msg_t;

    typedef struct packed {
        logic [63:0] digest_low;
        logic [63:0] digest_high;
    } dig_t;

    localparam logic [7:0] PI_TAB [256] = '{
        8'h24,8'h3F,8'h6A,8'h88,8'h85,8'hA3,8'h08,8'hD3,8'h13,8'h19,8'h8A,8'h2E,8'h03,8'h70,8'h73,8'h44,
        8'hA4,8'h09,8'h38,8'h22,8'h29,8'h9F,8'h31,8'hD0,8'h08,8'h2E,8'hFA,8'h98,8'hEC,8'h4E,8'h6C,8'h89,
        8'h45,8'h28,8'h21,8'hE6,8'h38,8'hD0,8'h13,8'h77,8'hBE,8'h54,8'h66,8'hCF,8'h34,8'hE9,8'h0C,8'h6C,
        8'hC0,8'hAC,8'h29,8'hB7,8'hC9,8'h7C,8'h50,8'hDD,8'h3F,8'h84,8'hD5,8'hB5,8'hB5,8'h47,8'h09,8'h17,
        8'h92,8'h16,8'hD5,8'hD9,8'h89,8'h79,8'hFB,8'h1B,8'hD1,8'h31,8'h0B,8'hA6,8'h98,8'hDF,8'hB5,8'hAC,
        8'h2F,8'hFD,8'h72,8'hDB,8'hD0,8'h1A,8'hDF,8'hB7,8'hB8,8'hE1,8'hAF,8'hED,8'h6A,8'h26,8'h7E,8'h96,
        8'hBA,8'h7C,8'h90,8'h45,8'hF1,8'h2C,8'h7F,8'h99,8'h24,8'hA1,8'h99,8'h47,8'hB3,8'h91,8'h6C,8'hF7,
        8'h08,8'h01,8'hF2,8'hE2,8'h85,8'h8E,8'hFC,8'h16,8'h63,8'h69,8'h20,8'hD8,8'h71,8'h57,8'h4E,8'h69,
        8'hA4,8'h58,8'hFE,8'hA3,8'hF4,8'h93,8'h3D,8'h7E,8'h0D,8'h95,8'h74,8'h8F,8'h72,8'h8E,8'hB6,8'h58,
        8'h71,8'h8B,8'hCD,8'h58,8'h82,8'h15,8'h4A,8'hEE,8'h7B,8'h54,8'hA4,8'h1D,8'hC2,8'h5A,8'h59,8'hB5,
        8'h9C,8'h30,8'hD5,8'h39,8'h2A,8'hF2,8'h60,8'h13,8'hC5,8'hD1,8'hB0,8'h23,8'h28,8'h60,8'h85,8'hF0,
        8'hCA,8'h41,8'h79,8'h18,8'hB8,8'hDB,8'h38,8'hEF,8'h8E,8'h79,8'hDC,8'hB0,8'h60,8'h3A,8'h18,8'h0E,
        8'h6C,8'h9E,8'h0E,8'h8B,8'hB0,8'h1E,8'h8A,8'h3E,8'hD7,8'h15,8'h77,8'hC1,8'hBD,8'h31,8'h4B,8'h27,
        8'h78,8'hAF,8'h2F,8'hDA,8'h55,8'h60,8'h5C,8'h60,8'hE6,8'h55,8'h25,8'hF3,8'hAA,8'h55,8'hAB,8'h94,
        8'h57,8'h48,8'h98,8'h62,8'h63,8'hE8,8'h14,8'h40,8'h55,8'hCA,8'h39,8'h6A,8'h2A,8'hAB,8'h10,8'hB6,
        8'hB4,8'hCC,8'h5C,8'h34,8'h11,8'h41,8'hE8,8'hCE,8'hA1,8'h54,8'h86,8'hAF,8'h7C,8'h72,8'hE9,8'h93
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // table lane j: pi bytes 16j to 16j+15, first byte in bits 7:0
    function automatic logic [127:0] pi_lane(input logic [3:0] j);
        logic [127:0] v;
        v = '0;
        for (int b = 0; b < 16; b++)
        begin
            v[8*b +: 8] = PI_TAB[{j, 4'(b)}];
        end
        return v;
    endfunction

endpackage

// File: hdl/arlh_aes_round.sv
// arlh_aes_round: one aes encryption round (shiftrows, subbytes, mixcolumns, key xor)
// depends on arlh_pkg for the s-box
`timescale 1ns / 1ps

module arlh_aes_round
    import arlh_pkg::*;
(
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    output logic [127:0] result
);

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [127:0] mixed;

    // byte split, shiftrows and subbytes
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[8*i +: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[r + 4*c] = SBOX[s[r + 4*((c + r) & 3)]];
            end
        end
    end

    // mixcolumns per column
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            mixed[32*c +: 8]      = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1]
                                    ^ t[4*c+2] ^ t[4*c+3];
            mixed[32*c + 8 +: 8]  = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2])
                                    ^ t[4*c+2] ^ t[4*c+3];
            mixed[32*c + 16 +: 8] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2])
                                    ^ xtime(t[4*c+3]) ^ t[4*c+3];
            mixed[32*c + 24 +: 8] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                                    ^ xtime(t[4*c+3]);
        end
    end

    assign result = mixed ^ round_key;

endmodule

// File: hdl/aes_round_lane_hash.sv
// Lane init runs after reset, after any register write and after a digest.
// Non-final word: the first word of a chunk is held in idle; the second adds a lane
// read, then one round of the shared aes unit.
// Final word: padded absorbs up to the last lane, the tree rounds, the final round,
// then the re-init; each round is a lane read, then one pass of the single aes unit.
// Reset: rst_n clears all control state and starts the lane init; msg_stall is high meanwhile.
// depends on arlh_pkg and arlh_aes_round
`timescale 1ns / 1ps

module aes_round_lane_hash
    import arlh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  msg_t        msg,
    output logic        dig_valid,
    input  logic        dig_stall,
    output dig_t        dig,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EX   = 3'd3;

    localparam logic [1:0] OP_ABS  = 2'd0;
    localparam logic [1:0] OP_PAD  = 2'd1;
    localparam logic [1:0] OP_TREE = 2'd2;
    localparam logic [1:0] OP_FIN  = 2'd3;

    logic [2:0]   state_reg, state_next;
    logic [1:0]   op_reg, op_next;
    logic [3:0]   j_reg, j_next;
    logic [3:0]   stride_reg, stride_next;
    logic [127:0] key_reg, key_next;
    logic [63:0]  k_reg, k_next;
    logic [63:0]  pending_reg, pending_next;
    logic [4:0]   pos_reg, pos_next;
    logic [63:0]  total_reg, total_next;
    logic         seed_en_reg, seed_en_next;
    logic [63:0]  seed0_reg, seed0_next;
    logic [63:0]  seed1_reg, seed1_next;
    logic [63:0]  seed2_reg, seed2_next;
    logic [63:0]  seed3_reg, seed3_next;
    logic         dig_valid_reg, dig_valid_next;
    dig_t         dig_reg, dig_next;

    // lane memory, lane i as {hi, lo}
    logic [127:0] lane_mem [LANE_COUNT];
    logic [127:0] rd_a_reg, rd_b_reg;
    logic         wr_en;
    logic [127:0] wr_data;

    logic [127:0] aes_x, aes_k, aes_out;
    logic [127:0] init_plain;
    logic         msg_take, cfg_take, out_blocked;
    logic [3:0]   bv_sat;
    logic [63:0]  mixed;
    logic [3:0]   chunk;
    logic [127:0] chunk_lane;

    assign msg_take    = msg_valid && !msg_stall;
    assign cfg_take    = cfg_valid && cfg_ready;
    assign msg_stall   = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_blocked = dig_valid_reg && dig_stall;
    assign dig_valid   = dig_valid_reg;
    assign dig         = dig_reg;

    // final word padding with table bytes at the same offsets
    assign bv_sat     = (msg.bytes_valid > 4'd8) ? 4'd8 : msg.bytes_valid;
    assign chunk      = pos_reg[4:1];
    assign chunk_lane = pi_lane(chunk);
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < bv_sat)
            begin
                mixed[8*b +: 8] = msg.message_word[8*b +: 8];
            end
            else
            begin
                mixed[8*b +: 8] = pos_reg[0] ? chunk_lane[64 + 8*b +: 8]
                                             : chunk_lane[8*b +: 8];
            end
        end
    end

    // shared aes round operand select
    assign init_plain = pi_lane(j_reg) ^ {seed1_reg ^ k_reg, seed0_reg ^ ~k_reg};
    always_comb
    begin
        if (state_reg == S_INIT)
        begin
            aes_x = init_plain;
            aes_k = {seed3_reg, seed2_reg};
        end
        else
        begin
            aes_x = rd_a_reg;
            unique case (op_reg)
                OP_TREE: aes_k = rd_b_reg;
                OP_FIN:  aes_k = {total_reg, ~total_reg};
                default: aes_k = key_reg;
            endcase
        end
    end

    arlh_aes_round u_aes (
        .state_in  (aes_x),
        .round_key (aes_k),
        .result    (aes_out)
    );

    // lane write data and enable
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = aes_out;
        if (state_reg == S_INIT)
        begin
            wr_en   = 1'b1;
            wr_data = seed_en_reg ? aes_out : pi_lane(j_reg);
        end
        else if (state_reg == S_EX && op_reg != OP_FIN)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lane_mem[j_reg] <= wr_data;
        end
        rd_a_reg <= lane_mem[j_reg];
        rd_b_reg <= lane_mem[j_reg + stride_reg];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        j_next         = j_reg;
        stride_next    = stride_reg;
        key_next       = key_reg;
        k_next         = k_reg;
        pending_next   = pending_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        seed_en_next   = seed_en_reg;
        seed0_next     = seed0_reg;
        seed1_next     = seed1_reg;
        seed2_next     = seed2_reg;
        seed3_next     = seed3_reg;
        dig_valid_next = dig_valid_reg && dig_stall;
        dig_next       = dig_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_take && !msg.last_word)
                begin
                    total_next = total_reg + 64'd8;
                    pos_next   = pos_reg + 5'd1;
                    if (pos_reg[0])
                    begin
                        key_next   = {msg.message_word, pending_reg};
                        j_next     = chunk;
                        op_next    = OP_ABS;
                        state_next = S_RD;
                    end
                    else
                    begin
                        pending_next = msg.message_word;
                    end
                end
                else if (msg_take)
                begin
                    total_next = total_reg + 64'(bv_sat);
                    state_next = S_RD;
                    if (pos_reg != 5'd0 || bv_sat != 4'd0)
                    begin
                        op_next  = OP_PAD;
                        j_next   = chunk;
                        key_next = pos_reg[0] ? {mixed, pending_reg}
                                              : {chunk_lane[127:64], mixed};
                    end
                    else
                    begin
                        op_next     = OP_TREE;
                        j_next      = 4'd0;
                        stride_next = 4'd8;
                    end
                end
            end
            S_INIT:
            begin
                k_next = k_reg + GOLDEN;
                j_next = j_reg + 4'd1;
                if (j_reg == 4'(LANE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = S_EX;
            end
            S_EX:
            begin
                unique case (op_reg)
                    OP_ABS:
                    begin
                        state_next = S_IDLE;
                    end
                    OP_PAD:
                    begin
                        state_next = S_RD;
                        if (j_reg == 4'(LANE_COUNT - 1))
                        begin
                            op_next     = OP_TREE;
                            j_next      = 4'd0;
                            stride_next = 4'd8;
                        end
                        else
                        begin
                            j_next   = j_reg + 4'd1;
                            key_next = pi_lane(j_reg + 4'd1);
                        end
                    end
                    OP_TREE:
                    begin
                        state_next = S_RD;
                        if (j_reg == stride_reg - 4'd1)
                        begin
                            j_next = 4'd0;
                            if (stride_reg == 4'd1)
                            begin
                                op_next = OP_FIN;
                            end
                            else
                            begin
                                stride_next = {1'b0, stride_reg[3:1]};
                            end
                        end
                        else
                        begin
                            j_next = j_reg + 4'd1;
                        end
                    end
                    OP_FIN:
                    begin
                        // wait for the output register to free up
                        if (!out_blocked)
                        begin
                            dig_valid_next = 1'b1;
                            dig_next       = '{digest_low: aes_out[63:0],
                                               digest_high: aes_out[127:64]};
                            state_next     = S_INIT;
                            j_next         = 4'd0;
                            k_next         = '0;
                            pending_next   = '0;
                            pos_next       = '0;
                            total_next     = '0;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // register write restarts the lanes and drops the message
        if (cfg_take && cfg_index <= REG_SEED_WORD3)
        begin
            unique case (cfg_index)
                REG_SEED_ENABLE: seed_en_next = cfg_data[0];
                REG_SEED_WORD0:  seed0_next   = cfg_data;
                REG_SEED_WORD1:  seed1_next   = cfg_data;
                REG_SEED_WORD2:  seed2_next   = cfg_data;
                default:         seed3_next   = cfg_data;
            endcase
            state_next   = S_INIT;
            j_next       = 4'd0;
            k_next       = '0;
            pending_next = '0;
            pos_next     = '0;
            total_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            op_reg        <= OP_ABS;
            j_reg         <= '0;
            stride_reg    <= 4'd8;
            k_reg         <= '0;
            pending_reg   <= '0;
            pos_reg       <= '0;
            total_reg     <= '0;
            seed_en_reg   <= 1'b0;
            seed0_reg     <= '0;
            seed1_reg     <= '0;
            seed2_reg     <= '0;
            seed3_reg     <= '0;
            dig_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            j_reg         <= j_next;
            stride_reg    <= stride_next;
            k_reg         <= k_next;
            pending_reg   <= pending_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            seed_en_reg   <= seed_en_next;
            seed0_reg     <= seed0_next;
            seed1_reg     <= seed1_next;
            seed2_reg     <= seed2_next;
            seed3_reg     <= seed3_next;
            dig_valid_reg <= dig_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        dig_reg <= dig_next;
    end

`ifndef NO_ASSERTIONS
    // tree stride is always a single power of two
    a_stride_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(stride_reg))
        else $error("tree stride not a power of two");

    // a single absorb returns straight to idle unless a register write intervenes
    a_abs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EX && op_reg == OP_ABS && !cfg_take) |=> state_reg == S_IDLE)
        else $error("single absorb did not finish");

    // the final round hands its digest over when the output is free
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EX && op_reg == OP_FIN && !out_blocked) |=> dig_valid)
        else $error("digest lost at final round");

    // a read always precedes an aes round on the lanes
    a_rd_ex: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EX) |-> $past(state_reg) == S_RD || $past(state_reg) == S_EX)
        else $error("round without a lane read");
`endif

endmodule
